FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// AST_PROP checks a property on the rising clock edge, off while reset is low.
// AST_NEVER checks that a condition is never true on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define AST_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define AST_PROP(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/ioep_pkg.sv
package ioep_pkg;

	localparam int OP_W      = 6;
	localparam int SITE_W    = 10;
	localparam int OPERAND_W = 64;
	localparam int CLASS_W   = 2;
	localparam int OUT_W     = 40;
	localparam int SLOT_W    = 4;
	localparam int SLOT_COUNT = 15;

	localparam logic [SLOT_W-1:0] NO_SLOT = 4'd15;

	localparam logic [OP_W-1:0] OP_ADD  = 6'd11;
	localparam logic [OP_W-1:0] OP_FADD = 6'd12;
	localparam logic [OP_W-1:0] OP_SUB  = 6'd13;
	localparam logic [OP_W-1:0] OP_FSUB = 6'd14;
	localparam logic [OP_W-1:0] OP_MUL  = 6'd15;
	localparam logic [OP_W-1:0] OP_FMUL = 6'd16;
	localparam logic [OP_W-1:0] OP_UDIV = 6'd17;
	localparam logic [OP_W-1:0] OP_SDIV = 6'd18;
	localparam logic [OP_W-1:0] OP_FDIV = 6'd19;
	localparam logic [OP_W-1:0] OP_SHL  = 6'd23;
	localparam logic [OP_W-1:0] OP_LSHR = 6'd24;
	localparam logic [OP_W-1:0] OP_ASHR = 6'd25;
	localparam logic [OP_W-1:0] OP_AND  = 6'd26;
	localparam logic [OP_W-1:0] OP_OR   = 6'd27;
	localparam logic [OP_W-1:0] OP_XOR  = 6'd28;

	localparam logic [CLASS_W-1:0] CLS_NONE = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_A    = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_B    = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_BOTH = 2'd3;

	localparam logic [OPERAND_W-1:0] INT_ONE = 64'd1;
	localparam logic [OPERAND_W-1:0] DBL_ONE = 64'h3FF0_0000_0000_0000;

	typedef struct packed {
		logic clear;
		logic capture;
		logic update;
	} ioep_cmd_t;

	typedef struct packed {
		logic clear_last;
	} ioep_sts_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [OP_W-1:0] op);
		logic [SLOT_W-1:0] slot;
		slot = NO_SLOT;
		if (op >= OP_ADD && op <= OP_FDIV)
			slot = SLOT_W'(op - OP_ADD);
		else if (op >= OP_SHL && op <= OP_XOR)
			slot = SLOT_W'(op - OP_SHL + 6'd9);
		return slot;
	endfunction

	function automatic logic dbl_zero(input logic [OPERAND_W-1:0] v);
		return v[OPERAND_W-2:0] == '0;
	endfunction

	function automatic logic [CLASS_W-1:0] classify(
		input logic [OP_W-1:0]      op,
		input logic [OPERAND_W-1:0] a,
		input logic [OPERAND_W-1:0] b,
		input logic                 dst_b
	);
		logic [CLASS_W-1:0] cls;
		cls = CLS_NONE;
		case (op) inside
			OP_ADD, OP_XOR: begin
				if (dst_b && a == '0)
					cls = CLS_A;
				else if (!dst_b && b == '0)
					cls = CLS_B;
			end
			OP_SUB, OP_SHL, OP_LSHR, OP_ASHR: begin
				if (!dst_b && b == '0)
					cls = CLS_B;
			end
			OP_MUL, OP_UDIV, OP_SDIV: begin
				if (dst_b && a == INT_ONE)
					cls = CLS_A;
				else if (!dst_b && b == INT_ONE)
					cls = CLS_B;
			end
			OP_AND, OP_OR: begin
				if (a == b)
					cls = CLS_BOTH;
			end
			OP_FADD: begin
				if (dst_b && dbl_zero(a))
					cls = CLS_A;
				else if (!dst_b && dbl_zero(b))
					cls = CLS_B;
			end
			OP_FSUB: begin
				if (!dst_b && dbl_zero(b))
					cls = CLS_B;
			end
			OP_FMUL: begin
				if (dst_b && a == DBL_ONE)
					cls = CLS_A;
				else if (!dst_b && b == DBL_ONE)
					cls = CLS_B;
			end
			OP_FDIV: begin
				if (!dst_b && b == DBL_ONE)
					cls = CLS_B;
			end
			default: cls = CLS_NONE;
		endcase
		return cls;
	endfunction

endpackage

FILE: rtl/ioep_ram.sv
module ioep_ram #(
	parameter int WIDTH = 160,
	parameter int DEPTH = 15360
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// hold the read word until the next read
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: rtl/ioep_ctrl.sv
`include "assert_macros.svh"

module ioep_ctrl
	import ioep_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ioep_sts_t status,
	output ioep_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	assign cmd.clear   = state_q == ST_CLEAR;
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.update  = (state_q == ST_UPDATE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// load a fresh result, or drop the one just taken
			if (cmd.update)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	`AST_PROP(a_accept_to_update, clk, arst_n, (in_valid && !in_stall) |=> (state_q == ST_UPDATE))
	`AST_PROP(a_result_from_update, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
	`AST_PROP(a_wait_on_full, clk, arst_n, (state_q == ST_UPDATE && out_valid_q && out_stall) |=> (state_q == ST_UPDATE))
	`AST_NEVER(a_no_result_in_clear, clk, arst_n, state_q == ST_CLEAR && out_valid_q)

endmodule

FILE: rtl/ioep_datapath.sv
module ioep_datapath
	import ioep_pkg::*;
#(
	parameter int SITE_COUNT   = 1024,
	parameter int COUNTER_BITS = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ioep_cmd_t            cmd,
	output ioep_sts_t            status,
	input  logic [OP_W-1:0]      op_code,
	input  logic [SITE_W-1:0]    site_id,
	input  logic [OPERAND_W-1:0] first_operand,
	input  logic [OPERAND_W-1:0] second_operand,
	input  logic                 dest_is_second,
	output logic [CLASS_W-1:0]   identity_class,
	output logic                 bad_event,
	output logic [OUT_W-1:0]     opcode_total,
	output logic [OUT_W-1:0]     opcode_identities,
	output logic [OUT_W-1:0]     site_a_count,
	output logic [OUT_W-1:0]     site_b_count,
	output logic [OUT_W-1:0]     site_both_count,
	output logic [OUT_W-1:0]     site_plain_count
);

	localparam int CB        = COUNTER_BITS;
	localparam int ROW_W     = 4 * CB;
	localparam int ROW_DEPTH = SLOT_COUNT * SITE_COUNT;
	localparam int ADDR_W    = $clog2(ROW_DEPTH);

	function automatic logic [CB-1:0] bump(input logic [CB-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// input decode
	logic [SLOT_W-1:0]  slot_in;
	logic               bad_in;
	logic [ADDR_W-1:0]  addr_in;

	assign slot_in = slot_of(op_code);
	assign bad_in  = (slot_in == NO_SLOT) || !(32'(site_id) < SITE_COUNT);
	assign addr_in = ADDR_W'(32'(slot_in) * SITE_COUNT + 32'(site_id));

	logic [SLOT_W-1:0]  slot_s1;
	logic [CLASS_W-1:0] cls_s1;
	logic               bad_s1;
	logic [ADDR_W-1:0]  addr_s1;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_s1 <= slot_in;
			cls_s1  <= classify(op_code, first_operand, second_operand, dest_is_second);
			bad_s1  <= bad_in;
			addr_s1 <= addr_in;
		end
	end

	// clearing sweep over the site counters
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clear)
			clr_addr_q <= clr_addr_q + 1'b1;
	end

	assign status.clear_last = clr_addr_q == ADDR_W'(ROW_DEPTH - 1);

	// site counter row: {plain, both, b, a}
	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  new_row;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [CB-1:0]     cnt_a, cnt_b, cnt_both, cnt_plain;
	logic [CB-1:0]     new_a, new_b, new_both, new_plain;

	assign cnt_a     = rd_row[CB-1:0];
	assign cnt_b     = rd_row[2*CB-1:CB];
	assign cnt_both  = rd_row[3*CB-1:2*CB];
	assign cnt_plain = rd_row[4*CB-1:3*CB];

	assign new_a     = (cls_s1 == CLS_A)    ? bump(cnt_a)     : cnt_a;
	assign new_b     = (cls_s1 == CLS_B)    ? bump(cnt_b)     : cnt_b;
	assign new_both  = (cls_s1 == CLS_BOTH) ? bump(cnt_both)  : cnt_both;
	assign new_plain = (cls_s1 == CLS_NONE) ? bump(cnt_plain) : cnt_plain;
	assign new_row   = {new_plain, new_both, new_b, new_a};

	assign ram_we    = cmd.clear || (cmd.update && !bad_s1);
	assign ram_waddr = cmd.clear ? clr_addr_q : addr_s1;
	assign ram_wdata = cmd.clear ? '0 : new_row;

	ioep_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROW_DEPTH)
	) u_site_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.capture),
		.raddr(addr_in),
		.rdata(rd_row)
	);

	// per-opcode counters
	logic [CB-1:0] totals_q [SLOT_COUNT];
	logic [CB-1:0] idents_q [SLOT_COUNT];
	logic [CB-1:0] new_tot, new_ident;

	assign new_tot   = bump(totals_q[slot_s1]);
	assign new_ident = (cls_s1 != CLS_NONE) ? bump(idents_q[slot_s1]) : idents_q[slot_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				totals_q[i] <= '0;
				idents_q[i] <= '0;
			end
		end else if (cmd.update && !bad_s1) begin
			totals_q[slot_s1] <= new_tot;
			idents_q[slot_s1] <= new_ident;
		end
	end

	// result register
	logic [CLASS_W-1:0] class_q;
	logic               bad_q;
	logic [OUT_W-1:0]   total_q, ident_q, a_q, b_q, both_q, plain_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			bad_q <= bad_s1;
			if (bad_s1) begin
				class_q <= CLS_NONE;
				total_q <= '0;
				ident_q <= '0;
				a_q     <= '0;
				b_q     <= '0;
				both_q  <= '0;
				plain_q <= '0;
			end else begin
				class_q <= cls_s1;
				total_q <= OUT_W'(new_tot);
				ident_q <= OUT_W'(new_ident);
				a_q     <= OUT_W'(new_a);
				b_q     <= OUT_W'(new_b);
				both_q  <= OUT_W'(new_both);
				plain_q <= OUT_W'(new_plain);
			end
		end
	end

	assign identity_class    = class_q;
	assign bad_event         = bad_q;
	assign opcode_total      = total_q;
	assign opcode_identities = ident_q;
	assign site_a_count      = a_q;
	assign site_b_count      = b_q;
	assign site_both_count   = both_q;
	assign site_plain_count  = plain_q;

endmodule

FILE: rtl/identity_operand_event_profiler_top.sv
// Flow: an accepted request is captured (decode latched, site row read), then in
// the update state, once the output register is free, its result is loaded there.
// One request at a time: no new request is accepted until the read-modify-write of
// the site counter RAM (registered read, then write back) for the last one is done.
// Reset: arst_n clears control state and per-opcode counters at once, then a sweep
// zeroes all 15 * SITE_COUNT rows (15360 at the default) of the site counter RAM,
// one row a cycle; in_stall stays high until the sweep ends.
module identity_operand_event_profiler_top
	import ioep_pkg::*;
#(
	parameter int SITE_COUNT   = 1024,
	parameter int COUNTER_BITS = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      op_code,
	input  logic [SITE_W-1:0]    site_id,
	input  logic [OPERAND_W-1:0] first_operand,
	input  logic [OPERAND_W-1:0] second_operand,
	input  logic                 dest_is_second,

	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CLASS_W-1:0]   identity_class,
	output logic                 bad_event,
	output logic [OUT_W-1:0]     opcode_total,
	output logic [OUT_W-1:0]     opcode_identities,
	output logic [OUT_W-1:0]     site_a_count,
	output logic [OUT_W-1:0]     site_b_count,
	output logic [OUT_W-1:0]     site_both_count,
	output logic [OUT_W-1:0]     site_plain_count
);

	// Commands from the sequencer to the datapath:
	//   clear   - write one zero row of the site RAM and advance the sweep
	//   capture - latch the request's decode and start the site row read
	//   update  - bump counters, write the row back, load the result register
	ioep_cmd_t cmd;
	ioep_sts_t status;

	// The sequencer accepts a request in idle even while a result still waits in
	// the output register; the update then holds until that result is taken.
	ioep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: classification, per-opcode counters in flops, per-site counters
	// packed four to a RAM row, and the result register.
	ioep_datapath #(
		.SITE_COUNT  (SITE_COUNT),
		.COUNTER_BITS(COUNTER_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.op_code          (op_code),
		.site_id          (site_id),
		.first_operand    (first_operand),
		.second_operand   (second_operand),
		.dest_is_second   (dest_is_second),
		.identity_class   (identity_class),
		.bad_event        (bad_event),
		.opcode_total     (opcode_total),
		.opcode_identities(opcode_identities),
		.site_a_count     (site_a_count),
		.site_b_count     (site_b_count),
		.site_both_count  (site_both_count),
		.site_plain_count (site_plain_count)
	);

endmodule
